/* src/npq_pkg.sv */
`timescale 1ns / 1ps

package npq_pkg;

   localparam int CHAN_W = 8;
   localparam int SLOT_W = 4;
   localparam int X_W    = 7;
   localparam int Y_W    = 9;
   localparam int TILE_W = 8;
   localparam int PIX_W  = 8;
   localparam int CODE_W = 5;
   localparam int DIST_W = 10;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   localparam logic [CODE_W-1:0] CODE_TRANSPARENT = '0;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic              action;
      logic [SLOT_W-1:0] palette_slot;
      logic [X_W-1:0]    pixel_x;
      logic [Y_W-1:0]    pixel_y;
      rgb_type           color;
   } req_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile_index;
      logic [PIX_W-1:0]  pixel_index;
      logic [CODE_W-1:0] color_code;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      rgb_type           color;
   } pal_wr_type;

endpackage

/* src/npq_chan_if.sv */
`timescale 1ns / 1ps

interface npq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [npq_pkg::SLOT_W-1:0]  palette_slot;
   logic [npq_pkg::X_W-1:0]     pixel_x;
   logic [npq_pkg::Y_W-1:0]     pixel_y;
   logic [npq_pkg::CHAN_W-1:0]  red;
   logic [npq_pkg::CHAN_W-1:0]  green;
   logic [npq_pkg::CHAN_W-1:0]  blue;

   modport source (
      output valid, action, palette_slot, pixel_x, pixel_y, red, green, blue,
      input  ready
   );
   modport sink (
      input  valid, action, palette_slot, pixel_x, pixel_y, red, green, blue,
      output ready
   );
endinterface

interface npq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [npq_pkg::TILE_W-1:0]  tile_index;
   logic [npq_pkg::PIX_W-1:0]   pixel_index;
   logic [npq_pkg::CODE_W-1:0]  color_code;

   modport source (
      output valid, tile_index, pixel_index, color_code,
      input  ready
   );
   modport sink (
      input  valid, tile_index, pixel_index, color_code,
      output ready
   );
endinterface

/* src/nearest_palette_pixel_quantizer.sv */
`timescale 1ns / 1ps

// Channel    Dir   Handshake     Payload
// req_chan   in    valid/ready   action, palette_slot, pixel_x, pixel_y, red, green, blue
// rsp_chan   out   valid/ready   tile_index, pixel_index, color_code
//
// One item per cycle while no result is stalled: input register, then distance
// lanes and compare tree, then result register. Palette loads take effect as
// they leave the input register; they and out-of-image pixels give no result.
// Synchronous reset clears the palette. A stalled result holds the input
// register; req_chan.ready is low in reset.

module nearest_palette_pixel_quantizer #(
   parameter int PALETTE_ENTRIES = 16,
   parameter int TILE_SIDE       = 16,
   parameter int IMAGE_WIDTH     = 128,
   parameter int IMAGE_HEIGHT    = 512
) (
   input logic        clock,
   input logic        reset,
   npq_req_if.sink    req_chan,
   npq_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int SUM_W = (IDX_W + 1 > npq_pkg::CODE_W) ? IDX_W + 1 : npq_pkg::CODE_W;

   npq_pkg::req_type    req_payload;
   npq_pkg::req_type    s0_data_ff;
   logic                s0_valid_ff;
   npq_pkg::rsp_type    rsp_data_in;
   npq_pkg::rsp_type    rsp_data_ff;
   logic                rsp_valid_ff;

   npq_pkg::pal_wr_type pal_wr;
   npq_pkg::rgb_type    palette [PALETTE_ENTRIES];
   logic [IDX_W-1:0]    best_idx;
   logic [SUM_W-1:0]    code_wide;
   logic                in_image;
   logic                produce;
   logic                out_free;
   logic                s0_advance;
   logic                req_ready;
   logic                magenta;

   assign req_payload.action       = req_chan.action;
   assign req_payload.palette_slot = req_chan.palette_slot;
   assign req_payload.pixel_x      = req_chan.pixel_x;
   assign req_payload.pixel_y      = req_chan.pixel_y;
   assign req_payload.color.red    = req_chan.red;
   assign req_payload.color.green  = req_chan.green;
   assign req_payload.color.blue   = req_chan.blue;

   assign in_image   = (int'(s0_data_ff.pixel_x) < IMAGE_WIDTH)
                    && (int'(s0_data_ff.pixel_y) < IMAGE_HEIGHT);
   assign produce    = (s0_data_ff.action == npq_pkg::ACTION_PIXEL) && in_image;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s0_advance = s0_valid_ff && (!produce || out_free);
   assign req_ready  = !reset && (!s0_valid_ff || s0_advance);

   assign req_chan.ready = req_ready;

   assign pal_wr.en    = s0_valid_ff && (s0_data_ff.action == npq_pkg::ACTION_LOAD)
                      && (int'(s0_data_ff.palette_slot) < PALETTE_ENTRIES);
   assign pal_wr.slot  = s0_data_ff.palette_slot;
   assign pal_wr.color = s0_data_ff.color;

   npq_palette #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock (clock),
      .reset (reset),
      .wr    (pal_wr),
      .entry (palette)
   );

   npq_nearest #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_nearest (
      .pixel    (s0_data_ff.color),
      .entry    (palette),
      .best_idx (best_idx)
   );

   npq_tile #(
      .TILE_SIDE   (TILE_SIDE),
      .IMAGE_WIDTH (IMAGE_WIDTH)
   ) u_tile (
      .pixel_x     (s0_data_ff.pixel_x),
      .pixel_y     (s0_data_ff.pixel_y),
      .tile_index  (rsp_data_in.tile_index),
      .pixel_index (rsp_data_in.pixel_index)
   );

   assign magenta   = (s0_data_ff.color.red == npq_pkg::CHAN_MAX)
                   && (s0_data_ff.color.green == npq_pkg::CHAN_MIN)
                   && (s0_data_ff.color.blue == npq_pkg::CHAN_MAX);
   assign code_wide = SUM_W'(best_idx) + SUM_W'(1);
   assign rsp_data_in.color_code = magenta ? npq_pkg::CODE_TRANSPARENT
                                           : code_wide[npq_pkg::CODE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s0_valid_ff <= req_chan.valid;
         end
         if (s0_advance && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         s0_data_ff <= req_payload;
      end
      if (s0_advance && produce) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tile_index  = rsp_data_ff.tile_index;
   assign rsp_chan.pixel_index = rsp_data_ff.pixel_index;
   assign rsp_chan.color_code  = rsp_data_ff.color_code;

endmodule

/* src/npq_palette.sv */
`timescale 1ns / 1ps

module npq_palette #(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  npq_pkg::pal_wr_type wr,
   output npq_pkg::rgb_type    entry [ENTRIES]
);

   npq_pkg::rgb_type entry_ff [ENTRIES];

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (reset) begin
            entry_ff[i] <= '0;
         end else if (wr.en && int'(wr.slot) == i) begin
            entry_ff[i] <= wr.color;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         entry[i] = entry_ff[i];
      end
   end

endmodule

/* src/npq_nearest.sv */
`timescale 1ns / 1ps

module npq_nearest #(
   parameter int ENTRIES = 16,
   localparam int IDX_W  = $clog2(ENTRIES)
) (
   input  npq_pkg::rgb_type   pixel,
   input  npq_pkg::rgb_type   entry [ENTRIES],
   output logic [IDX_W-1:0]   best_idx
);

   localparam int LEAVES = 1 << IDX_W;

   logic [npq_pkg::DIST_W-1:0] node_dist [1:2*LEAVES-1];
   logic [IDX_W-1:0]           node_idx  [1:2*LEAVES-1];
   logic                       node_ok   [1:2*LEAVES-1];

   function automatic logic [npq_pkg::DIST_W-1:0] chan_diff(
      input logic [npq_pkg::CHAN_W-1:0] a,
      input logic [npq_pkg::CHAN_W-1:0] b
   );
      logic [npq_pkg::CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return npq_pkg::DIST_W'(d);
   endfunction

   // L1 distance per lane, then a compare tree; left side wins ties
   always_comb begin
      for (int k = 0; k < LEAVES; k++) begin
         if (k < ENTRIES) begin
            node_ok[LEAVES+k]   = 1'b1;
            node_idx[LEAVES+k]  = IDX_W'(k);
            node_dist[LEAVES+k] = chan_diff(entry[k].red,   pixel.red)
                                + chan_diff(entry[k].green, pixel.green)
                                + chan_diff(entry[k].blue,  pixel.blue);
         end else begin
            node_ok[LEAVES+k]   = 1'b0;
            node_idx[LEAVES+k]  = '0;
            node_dist[LEAVES+k] = '0;
         end
      end
      for (int k = LEAVES - 1; k >= 1; k--) begin
         if (node_ok[2*k+1] && (!node_ok[2*k] || node_dist[2*k+1] < node_dist[2*k])) begin
            node_ok[k]   = 1'b1;
            node_idx[k]  = node_idx[2*k+1];
            node_dist[k] = node_dist[2*k+1];
         end else begin
            node_ok[k]   = node_ok[2*k];
            node_idx[k]  = node_idx[2*k];
            node_dist[k] = node_dist[2*k];
         end
      end
      best_idx = node_idx[1];
   end

endmodule

/* src/npq_const_div.sv */
`timescale 1ns / 1ps

module npq_const_div #(
   parameter int WIDTH   = 7,
   parameter int DIVISOR = 16
) (
   input  logic [WIDTH-1:0] value,
   output logic [WIDTH-1:0] quot,
   output logic [WIDTH-1:0] rem
);

   localparam int SHIFT   = WIDTH + 1;
   localparam int RECIP   = (1 << SHIFT) / DIVISOR;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = WIDTH + RECIP_W;

   logic [PROD_W-1:0] prod;
   logic [WIDTH-1:0]  est;
   logic [WIDTH-1:0]  back;
   logic [WIDTH-1:0]  rem0;

   // reciprocal estimate is exact or one low
   always_comb begin
      prod = PROD_W'(value) * PROD_W'(RECIP);
      est  = WIDTH'(prod >> SHIFT);
      back = est * WIDTH'(DIVISOR);
      rem0 = value - back;
      if (rem0 >= WIDTH'(DIVISOR)) begin
         quot = est + WIDTH'(1);
         rem  = rem0 - WIDTH'(DIVISOR);
      end else begin
         quot = est;
         rem  = rem0;
      end
   end

endmodule

/* src/npq_tile.sv */
`timescale 1ns / 1ps

module npq_tile #(
   parameter int TILE_SIDE   = 16,
   parameter int IMAGE_WIDTH = 128
) (
   input  logic [npq_pkg::X_W-1:0]    pixel_x,
   input  logic [npq_pkg::Y_W-1:0]    pixel_y,
   output logic [npq_pkg::TILE_W-1:0] tile_index,
   output logic [npq_pkg::PIX_W-1:0]  pixel_index
);

   localparam int TILES_PER_ROW = IMAGE_WIDTH / TILE_SIDE;

   logic [npq_pkg::X_W-1:0] x_quot;
   logic [npq_pkg::X_W-1:0] x_rem;
   logic [npq_pkg::Y_W-1:0] y_quot;
   logic [npq_pkg::Y_W-1:0] y_rem;

   npq_const_div #(
      .WIDTH   (npq_pkg::X_W),
      .DIVISOR (TILE_SIDE)
   ) u_div_x (
      .value (pixel_x),
      .quot  (x_quot),
      .rem   (x_rem)
   );

   npq_const_div #(
      .WIDTH   (npq_pkg::Y_W),
      .DIVISOR (TILE_SIDE)
   ) u_div_y (
      .value (pixel_y),
      .quot  (y_quot),
      .rem   (y_rem)
   );

   // only the low field bits are kept, so products are formed at field width
   assign tile_index  = npq_pkg::TILE_W'(x_quot)
                      + npq_pkg::TILE_W'(y_quot) * npq_pkg::TILE_W'(TILES_PER_ROW);
   assign pixel_index = npq_pkg::PIX_W'(x_rem)
                      + npq_pkg::PIX_W'(y_rem) * npq_pkg::PIX_W'(TILE_SIDE);

endmodule

/* src/npq_checker.sv */
`timescale 1ns / 1ps

module npq_checker #(
   parameter int PALETTE_ENTRIES = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [npq_pkg::TILE_W-1:0]  rsp_tile_index,
   input logic [npq_pkg::PIX_W-1:0]   rsp_pixel_index,
   input logic [npq_pkg::CODE_W-1:0]  rsp_color_code
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |-> !req_ready ##1 !rsp_valid)
      else $error("outputs active after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_index)
         && $stable(rsp_pixel_index) && $stable(rsp_color_code))
      else $error("stalled result changed");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a transfer two cycles earlier");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_color_code) <= PALETTE_ENTRIES) || (PALETTE_ENTRIES >= 32))
      else $error("color code beyond palette");

endmodule

bind nearest_palette_pixel_quantizer npq_checker #(
   .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_npq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_tile_index  (rsp_chan.tile_index),
   .rsp_pixel_index (rsp_chan.pixel_index),
   .rsp_color_code  (rsp_chan.color_code)
);

/* tb/sv/npq_result_checker.sv */
`timescale 1ns / 1ps

module npq_result_checker #(
   parameter int PALETTE_ENTRIES = 16,
   parameter int TILE_SIDE       = 16,
   parameter int IMAGE_WIDTH     = 128,
   parameter int IMAGE_HEIGHT    = 512
) (
   input  logic clock,
   input  logic reset,
   npq_req_if   req_mon,
   npq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   npq_pkg::rgb_type palette_colors [PALETTE_ENTRIES];
   npq_pkg::rsp_type expected_results [$];

   function automatic int channel_gap(logic [npq_pkg::CHAN_W-1:0] a,
                                      logic [npq_pkg::CHAN_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // L1 distance search, lowest index wins a tie
   function automatic logic [npq_pkg::CODE_W-1:0] nearest_code(npq_pkg::rgb_type px);
      int best_idx;
      int best_dist;
      int lane_dist;
      best_idx  = 0;
      best_dist = 0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         lane_dist = channel_gap(palette_colors[i].red, px.red)
                   + channel_gap(palette_colors[i].green, px.green)
                   + channel_gap(palette_colors[i].blue, px.blue);
         if (i == 0 || lane_dist < best_dist) begin
            best_dist = lane_dist;
            best_idx  = i;
         end
      end
      return npq_pkg::CODE_W'(best_idx + 1);
   endfunction

   always @(posedge clock) begin
      npq_pkg::rsp_type got;
      npq_pkg::rsp_type want;
      npq_pkg::rgb_type px;
      int      x;
      int      y;
      bit      bad;
      if (reset) begin
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            palette_colors[i] = '0;
         end
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.tile_index  = rsp_mon.tile_index;
            got.pixel_index = rsp_mon.pixel_index;
            got.color_code  = rsp_mon.color_code;
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer: tile_index %0d pixel_index %0d color_code %0d",
                      got.tile_index, got.pixel_index, got.color_code);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               bad  = 1'b0;
               if (got.tile_index !== want.tile_index) begin
                  $error("tile_index mismatch: expected %0d, actual %0d",
                         want.tile_index, got.tile_index);
                  bad = 1'b1;
               end
               if (got.pixel_index !== want.pixel_index) begin
                  $error("pixel_index mismatch: expected %0d, actual %0d",
                         want.pixel_index, got.pixel_index);
                  bad = 1'b1;
               end
               if (got.color_code !== want.color_code) begin
                  $error("color_code mismatch: expected %0d, actual %0d",
                         want.color_code, got.color_code);
                  bad = 1'b1;
               end
               if (bad) begin
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            px.red   = req_mon.red;
            px.green = req_mon.green;
            px.blue  = req_mon.blue;
            x        = int'(req_mon.pixel_x);
            y        = int'(req_mon.pixel_y);
            if (req_mon.action == npq_pkg::ACTION_LOAD) begin
               if (int'(req_mon.palette_slot) < PALETTE_ENTRIES) begin
                  palette_colors[req_mon.palette_slot] = px;
               end
            end else if (x < IMAGE_WIDTH && y < IMAGE_HEIGHT) begin
               want.tile_index  = npq_pkg::TILE_W'(x / TILE_SIDE
                                  + (y / TILE_SIDE) * (IMAGE_WIDTH / TILE_SIDE));
               want.pixel_index = npq_pkg::PIX_W'(x % TILE_SIDE
                                  + (y % TILE_SIDE) * TILE_SIDE);
               if (px.red == npq_pkg::CHAN_MAX && px.green == npq_pkg::CHAN_MIN
                   && px.blue == npq_pkg::CHAN_MAX) begin
                  want.color_code = npq_pkg::CODE_TRANSPARENT;
               end else begin
                  want.color_code = nearest_code(px);
               end
               expected_results.push_back(want);
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

/* tb/sv/nearest_palette_pixel_quantizer_tb.sv */
`timescale 1ns / 1ps

module nearest_palette_pixel_quantizer_tb;

   localparam int PALETTE_ENTRIES = 16;
   localparam int TILE_SIDE       = 16;
   localparam int IMAGE_WIDTH     = 128;
   localparam int IMAGE_HEIGHT    = 512;
   localparam int RANDOM_ITEMS    = 1650;
   localparam int CALM_ITEMS      = 200;
   localparam int STALL_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 10;

   logic clock;
   logic reset;
   bit   calm = 1'b0;
   int   fail_count;
   int   pending_count;
   int   stall_cycles = 0;

   npq_pkg::rgb_type loaded_colors [PALETTE_ENTRIES];

   npq_req_if req_chan ();
   npq_rsp_if rsp_chan ();

   nearest_palette_pixel_quantizer #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .TILE_SIDE       (TILE_SIDE),
      .IMAGE_WIDTH     (IMAGE_WIDTH),
      .IMAGE_HEIGHT    (IMAGE_HEIGHT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   npq_result_checker #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .TILE_SIDE       (TILE_SIDE),
      .IMAGE_WIDTH     (IMAGE_WIDTH),
      .IMAGE_HEIGHT    (IMAGE_HEIGHT)
   ) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT - 1) begin
         $display("nearest_palette_pixel_quantizer verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic npq_pkg::req_type load_req(int slot, npq_pkg::rgb_type c);
      npq_pkg::req_type t;
      t              = '0;
      t.action       = npq_pkg::ACTION_LOAD;
      t.palette_slot = npq_pkg::SLOT_W'(slot);
      t.color        = c;
      return t;
   endfunction

   function automatic npq_pkg::req_type pixel_req(int x, int y, npq_pkg::rgb_type c);
      npq_pkg::req_type t;
      t         = '0;
      t.action  = npq_pkg::ACTION_PIXEL;
      t.pixel_x = npq_pkg::X_W'(x);
      t.pixel_y = npq_pkg::Y_W'(y);
      t.color   = c;
      return t;
   endfunction

   function automatic logic [npq_pkg::CHAN_W-1:0] jitter(logic [npq_pkg::CHAN_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) begin
         v = 0;
      end
      if (v > 255) begin
         v = 255;
      end
      return npq_pkg::CHAN_W'(v);
   endfunction

   function automatic npq_pkg::rgb_type random_color();
      npq_pkg::rgb_type c;
      c.red   = npq_pkg::CHAN_W'($urandom_range(0, 255));
      c.green = npq_pkg::CHAN_W'($urandom_range(0, 255));
      c.blue  = npq_pkg::CHAN_W'($urandom_range(0, 255));
      return c;
   endfunction

   // mostly pixels; many land on or near a loaded color, some duplicate loads for ties
   function automatic npq_pkg::req_type random_req();
      npq_pkg::req_type t;
      npq_pkg::rgb_type c;
      int      pick;
      int      src;
      pick         = $urandom_range(0, 99);
      src          = $urandom_range(0, PALETTE_ENTRIES - 1);
      t            = '0;
      t.palette_slot = npq_pkg::SLOT_W'($urandom_range(0, 15));
      t.pixel_x    = npq_pkg::X_W'($urandom_range(0, 127));
      t.pixel_y    = npq_pkg::Y_W'($urandom_range(0, 511));
      if (pick < 20) begin
         t.action = npq_pkg::ACTION_LOAD;
         t.color  = ($urandom_range(0, 3) == 0) ? loaded_colors[src] : random_color();
      end else begin
         t.action = npq_pkg::ACTION_PIXEL;
         if (pick < 30) begin
            t.color = '{npq_pkg::CHAN_MAX, npq_pkg::CHAN_MIN, npq_pkg::CHAN_MAX};
         end else if (pick < 50) begin
            t.color = loaded_colors[src];
         end else if (pick < 65) begin
            c       = loaded_colors[src];
            t.color = '{jitter(c.red), jitter(c.green), jitter(c.blue)};
         end else begin
            t.color = random_color();
         end
      end
      return t;
   endfunction

   task automatic send_req(input npq_pkg::req_type t);
      req_chan.valid        <= 1'b1;
      req_chan.action       <= t.action;
      req_chan.palette_slot <= t.palette_slot;
      req_chan.pixel_x      <= t.pixel_x;
      req_chan.pixel_y      <= t.pixel_y;
      req_chan.red          <= t.color.red;
      req_chan.green        <= t.color.green;
      req_chan.blue         <= t.color.blue;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      if (t.action == npq_pkg::ACTION_LOAD) begin
         loaded_colors[t.palette_slot] = t.color;
      end
      @(negedge clock);
   endtask

   task automatic sender_gap(input bit allowed);
      if (allowed && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   initial begin
      npq_pkg::rgb_type black;
      npq_pkg::rgb_type white;
      npq_pkg::rgb_type magenta;
      npq_pkg::rgb_type near_magenta;
      black        = '{npq_pkg::CHAN_MIN, npq_pkg::CHAN_MIN, npq_pkg::CHAN_MIN};
      white        = '{npq_pkg::CHAN_MAX, npq_pkg::CHAN_MAX, npq_pkg::CHAN_MAX};
      magenta      = '{npq_pkg::CHAN_MAX, npq_pkg::CHAN_MIN, npq_pkg::CHAN_MAX};
      near_magenta = '{npq_pkg::CHAN_MAX, npq_pkg::CHAN_MIN, 8'hFE};
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         loaded_colors[i] = '0;
      end
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.action       = npq_pkg::ACTION_LOAD;
      req_chan.palette_slot = '0;
      req_chan.pixel_x      = '0;
      req_chan.pixel_y      = '0;
      req_chan.red          = '0;
      req_chan.green        = '0;
      req_chan.blue         = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // palette still all zero: every entry ties
      send_req(pixel_req(0, 0, black));
      send_req(pixel_req(127, 511, white));
      send_req(pixel_req(5, 17, magenta));
      send_req(pixel_req(17, 5, near_magenta));
      sender_gap(1'b1);
      send_req(load_req(15, white));
      send_req(load_req(0, '{8'h01, 8'h02, 8'h03}));
      send_req(load_req(7, near_magenta));
      send_req(load_req(9, near_magenta));
      send_req(pixel_req(127, 0, white));
      send_req(pixel_req(0, 511, near_magenta));
      send_req(pixel_req(64, 256, magenta));
      send_req(pixel_req(16, 16, '{npq_pkg::CHAN_MAX, 8'h01, npq_pkg::CHAN_MAX}));
      send_req(pixel_req(15, 15, '{8'hFE, npq_pkg::CHAN_MIN, npq_pkg::CHAN_MAX}));
      send_req(load_req(0, black));
      send_req(pixel_req(1, 1, black));
      send_req(pixel_req(126, 510, '{8'h80, 8'h80, 8'h80}));
      send_req(load_req(3, '{8'hAA, 8'h55, 8'hAA}));
      send_req(pixel_req(85, 341, '{8'h55, 8'hAA, 8'h55}));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         if (n == RANDOM_ITEMS / 2) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
            while (pending_count != 0) begin
               @(negedge clock);
            end
         end else begin
            sender_gap(!calm && !(n >= 400 && n < 550));
         end
         send_req(random_req());
      end

      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("nearest_palette_pixel_quantizer verification clean");
      end else begin
         $display("nearest_palette_pixel_quantizer verification failed");
      end
      $finish;
   end

endmodule
